### rtl/core/pfa_pkg.sv
// pfa_pkg: shared types and codes for the partition fit allocator
// operation and policy codes, per-cell control bundle
// no dependencies
package pfa_pkg;

    localparam int FIELD_IDX_W = 3;  // width of part_index and chosen_index
    localparam int POLICY_W    = 2;
    localparam int SCAN_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_RSVD  = 2'd3
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_POLICY    = 2'd0,
        CFG_BLOCKS_IN_USE = 2'd1,
        CFG_SPARE2        = 2'd2,
        CFG_SPARE3        = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2,
        ST_SPARE  = 2'd3
    } state_t;

    // control seen by every cell while one item is in flight
    typedef struct packed {
        func_t   func;
        policy_t policy;
    } cell_ctrl_t;

endpackage

### rtl/core/pfa_cell.sv
// pfa_cell: one partition of the allocator chain
// holds one free size, refines the passing candidate, applies the final subtract
// depends on pfa_pkg
module pfa_cell #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 3,
    parameter int INDEX     = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfa_pkg::cell_ctrl_t  ctrl,
    input  logic [SIZE_BITS-1:0] amount,
    input  logic                 addr_hit,
    input  logic                 scan_en,
    input  logic                 commit_en,
    input  logic                 commit_hit,
    input  logic                 tok_valid_in,
    input  logic                 tok_found_in,
    input  logic [IDX_W-1:0]     tok_pick_in,
    input  logic [SIZE_BITS-1:0] tok_free_in,
    output logic                 tok_valid_out,
    output logic                 tok_found_out,
    output logic [IDX_W-1:0]     tok_pick_out,
    output logic [SIZE_BITS-1:0] tok_free_out
);
    import pfa_pkg::*;

    logic [SIZE_BITS-1:0] free_reg, free_next;
    logic                 valid_reg, valid_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] cand_reg, cand_next;
    logic                 fits, take;

    assign fits = scan_en && (free_reg >= amount);

    always_comb begin
        take = 1'b0;
        if (fits) begin
            unique case (ctrl.policy)
                POL_BEST:  take = !tok_found_in || (free_reg < tok_free_in);
                POL_WORST: take = !tok_found_in || (free_reg > tok_free_in);
                default:   take = !tok_found_in;
            endcase
        end
    end

    always_comb begin
        free_next  = free_reg;
        valid_next = tok_valid_in;
        found_next = tok_found_in;
        pick_next  = tok_pick_in;
        cand_next  = tok_free_in;
        if (tok_valid_in) begin
            unique case (ctrl.func)
                FUNC_LOAD: begin
                    if (addr_hit) begin
                        free_next  = amount;
                        found_next = 1'b1;
                        pick_next  = IDX_W'(INDEX);
                        cand_next  = amount;
                    end
                end
                FUNC_READ: begin
                    if (addr_hit) begin
                        found_next = 1'b1;
                        pick_next  = IDX_W'(INDEX);
                        cand_next  = free_reg;
                    end
                end
                FUNC_ALLOC: begin
                    if (take) begin
                        found_next = 1'b1;
                        pick_next  = IDX_W'(INDEX);
                        cand_next  = free_reg;
                    end
                end
                default: ;
            endcase
        end
        // the winning partition gives up the request
        if (commit_en && commit_hit) begin
            free_next = free_reg - amount;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            free_reg  <= free_next;
            valid_reg <= valid_next;
        end
        found_reg <= found_next;
        pick_reg  <= pick_next;
        cand_reg  <= cand_next;
    end

    assign tok_valid_out = valid_reg;
    assign tok_found_out = found_reg;
    assign tok_pick_out  = pick_reg;
    assign tok_free_out  = cand_reg;

endmodule

### rtl/core/partition_fit_allocator_core.sv
// partition_fit_allocator_core: fixed-partition allocator under first, best or worst fit
// a chain of NUM_PARTS pfa_cell instances with a small sequencer and output register
// depends on pfa_pkg and pfa_cell
//
// sequence: after acceptance an empty candidate is launched, walks the cell chain one cell per
//   cycle, is captured at the chain end and then commits once the output register is free;
//   a new item is accepted only after the last one has committed, and a waiting result does not
//   block acceptance, only the commit of the next item
// reset: aresetn synchronous active low; all free sizes zero, policy first fit,
//   blocks_in_use 8, no result pending
module partition_fit_allocator_core #(
    parameter int NUM_PARTS = 8,
    parameter int SIZE_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input items
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // [2:0] part_index, [SIZE_BITS+2:3] amount, rest zero
    input  logic [((SIZE_BITS+3+7)/8)*8-1:0]         s_tdata,
    // [1:0] func
    input  logic [1:0]                               s_tuser,
    // result items
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // [2:0] chosen_index, [SIZE_BITS+2:3] size_left, rest zero
    output logic [((SIZE_BITS+3+7)/8)*8-1:0]         m_tdata,
    // [0] granted
    output logic [0:0]                               m_tuser,
    // register writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]           cfg_data
);
    import pfa_pkg::*;

    localparam int IDX_W  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int DATA_W = ((SIZE_BITS + 3 + 7) / 8) * 8;

    // configuration registers
    policy_t           policy_reg;
    logic [SCAN_W-1:0] blocks_reg;

    // sequencer
    state_t state_reg, state_next;
    logic   start_reg, start_next;
    logic   accept, out_free, commit_en, capture;

    // operation held stable for the whole walk
    func_t                func_reg;
    logic [FIELD_IDX_W-1:0] idx_reg;
    logic [SIZE_BITS-1:0] amount_reg;

    // final candidate captured at the chain end
    logic                 res_found_reg;
    logic [IDX_W-1:0]     res_pick_reg;
    logic [SIZE_BITS-1:0] res_free_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic                 granted_reg;
    logic [FIELD_IDX_W-1:0] chosen_reg;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_calc;
    logic [IDX_W+FIELD_IDX_W-1:0] pick_wide;

    // candidate chain between cells
    logic                 tok_valid [0:NUM_PARTS];
    logic                 tok_found [0:NUM_PARTS];
    logic [IDX_W-1:0]     tok_pick  [0:NUM_PARTS];
    logic [SIZE_BITS-1:0] tok_free  [0:NUM_PARTS];

    cell_ctrl_t ctrl;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign ctrl.func   = func_reg;
    assign ctrl.policy = policy_reg;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIRST;
            blocks_reg <= SCAN_W'(8);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FIT_POLICY:    policy_reg <= policy_t'(cfg_data[POLICY_W-1:0]);
                CFG_BLOCKS_IN_USE: blocks_reg <= cfg_data[SCAN_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_SCAN;
            ST_SCAN:   if (tok_valid[NUM_PARTS]) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        start_next = 1'b0;
        capture    = 1'b0;
        commit_en  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   begin
                s_tready   = 1'b1;
                start_next = s_tvalid;
            end
            ST_SCAN:   capture = tok_valid[NUM_PARTS];
            ST_FINISH: commit_en = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= func_t'(s_tuser);
            idx_reg    <= s_tdata[FIELD_IDX_W-1:0];
            amount_reg <= s_tdata[FIELD_IDX_W+SIZE_BITS-1:FIELD_IDX_W];
        end
        if (capture) begin
            res_found_reg <= tok_found[NUM_PARTS];
            res_pick_reg  <= tok_pick[NUM_PARTS];
            res_free_reg  <= tok_free[NUM_PARTS];
        end
    end

    // chain head: empty candidate launched in the cycle after acceptance
    assign tok_valid[0] = start_reg;
    assign tok_found[0] = 1'b0;
    assign tok_pick[0]  = '0;
    assign tok_free[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_PARTS; gi++) begin : g_cell
            logic addr_hit, scan_en, commit_hit;
            // index compares in 32 bits so any partition count works
            assign addr_hit   = (32'(idx_reg) == gi);
            assign scan_en    = (gi < 32'(blocks_reg));
            assign commit_hit = (res_pick_reg == IDX_W'(gi));

            pfa_cell #(
                .SIZE_BITS (SIZE_BITS),
                .IDX_W     (IDX_W),
                .INDEX     (gi)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctrl          (ctrl),
                .amount        (amount_reg),
                .addr_hit      (addr_hit),
                .scan_en       (scan_en),
                .commit_en     (commit_en && res_found_reg && (func_reg == FUNC_ALLOC)),
                .commit_hit    (commit_hit),
                .tok_valid_in  (tok_valid[gi]),
                .tok_found_in  (tok_found[gi]),
                .tok_pick_in   (tok_pick[gi]),
                .tok_free_in   (tok_free[gi]),
                .tok_valid_out (tok_valid[gi+1]),
                .tok_found_out (tok_found[gi+1]),
                .tok_pick_out  (tok_pick[gi+1]),
                .tok_free_out  (tok_free[gi+1])
            );
        end
    endgenerate

    // size left: allocations subtract, loads and reads report as stored, nothing found reports zero
    always_comb begin
        left_calc = '0;
        if (res_found_reg) begin
            if (func_reg == FUNC_ALLOC) begin
                left_calc = res_free_reg - amount_reg;
            end else begin
                left_calc = res_free_reg;
            end
        end
    end

    // chosen index is reported in three bits
    assign pick_wide = {{FIELD_IDX_W{1'b0}}, res_pick_reg};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (commit_en) begin
            granted_reg <= res_found_reg;
            chosen_reg  <= res_found_reg ? pick_wide[FIELD_IDX_W-1:0] : '0;
            left_reg    <= left_calc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = granted_reg;
    assign m_tdata  = DATA_W'({left_reg, chosen_reg});

endmodule

### bench/partition_fit_allocator_core_test.sv
// partition_fit_allocator_core_test: self-checking bench for the partition fit allocator
// drives load, allocate and read items under every fit policy and varied scan counts, checks each result
// depends on pfa_pkg and partition_fit_allocator_core
module partition_fit_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int PARTS         = 8;
    localparam int SIZE_W        = 16;
    localparam int BUS_W         = ((SIZE_W + 3 + 7) / 8) * 8;
    localparam int STUCK_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 125;
    localparam int DRAIN_CYCLES  = 20;

    // one result item as the bench sees it
    typedef struct packed {
        logic              granted;
        logic [2:0]        part;
        logic [SIZE_W-1:0] remain;
    } alloc_result_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    // one line of the directed table: an item or a register write
    typedef struct packed {
        row_kind_t         kind;
        func_t             op;
        logic [2:0]        part;
        logic [SIZE_W-1:0] amount;
        cfg_reg_t          target;
        logic [3:0]        reg_value;
        logic              pinned;  // known answer typed into the table
        alloc_result_t     want;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BUS_W-1:0]      s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BUS_W-1:0]      m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // known answer travelling alongside the item on the input side
    logic                  fixed_on;
    alloc_result_t         fixed_want;

    // bench copy of the partition table and registers
    logic [SIZE_W-1:0]     part_free [PARTS];
    policy_t               fit_mode;
    logic [3:0]            scan_limit;

    alloc_result_t         awaited_results [$];
    row_t                  directed_rows [$];
    int                    mismatches;
    int                    stuck_cycles;
    int                    src_gap_pct;     // chance per item of a sender gap
    int                    sink_stall_pct;  // chance per cycle of a receiver stall

    partition_fit_allocator_core #(
        .NUM_PARTS (PARTS),
        .SIZE_BITS (SIZE_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [2:0] part_index, [18:3] amount, rest zero
        .s_tuser   (s_tuser),    // [1:0] func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [2:0] chosen_index, [18:3] size_left, rest zero
        .m_tuser   (m_tuser),    // [0] granted
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_partition_table();
        for (int i = 0; i < PARTS; i++) begin
            part_free[i] = '0;
        end
        fit_mode   = POL_FIRST;
        scan_limit = 4'd8;
    endfunction

    function automatic void apply_register(cfg_reg_t target, logic [3:0] value);
        case (target)
            CFG_FIT_POLICY:    fit_mode   = policy_t'(value[1:0]);
            CFG_BLOCKS_IN_USE: scan_limit = value;
            default: ;  // spare indexes hold nothing
        endcase
    endfunction

    // applies one item to the bench table and returns the result it should give
    function automatic alloc_result_t predict_partition_op(func_t op, logic [2:0] part,
                                                           logic [SIZE_W-1:0] amount);
        alloc_result_t     res;
        int                scan;
        bit                found;
        logic [2:0]        pick;
        logic [SIZE_W-1:0] key;
        res   = '0;
        found = 1'b0;
        pick  = '0;
        key   = '0;
        // a scan count above the table size covers the whole table
        scan  = (scan_limit > 4'd8) ? PARTS : int'(scan_limit);
        case (op)
            FUNC_LOAD, FUNC_READ: begin
                if (op == FUNC_LOAD) begin
                    part_free[part] = amount;
                end
                res = {1'b1, part, part_free[part]};
            end
            FUNC_ALLOC: begin
                // a zero request fits everywhere, even an empty partition
                for (int i = 0; i < scan; i++) begin
                    if (part_free[i] >= amount) begin
                        case (fit_mode)
                            POL_BEST: begin
                                // least leftover, strict compare keeps the lower index on ties
                                if (!found || (part_free[i] - amount) < key) begin
                                    found = 1'b1;
                                    pick  = i[2:0];
                                    key   = part_free[i] - amount;
                                end
                            end
                            POL_WORST: begin
                                if (!found || part_free[i] > key) begin
                                    found = 1'b1;
                                    pick  = i[2:0];
                                    key   = part_free[i];
                                end
                            end
                            default: begin
                                // first fit, the unused policy code acts the same
                                if (!found) begin
                                    found = 1'b1;
                                    pick  = i[2:0];
                                end
                            end
                        endcase
                    end
                end
                if (found) begin
                    part_free[pick] = part_free[pick] - amount;
                    res = {1'b1, pick, part_free[pick]};
                end
            end
            default: res = '0;  // unused function code changes nothing
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- directed table

    function automatic void add_row(row_kind_t kind, func_t op, logic [2:0] part,
                                    logic [SIZE_W-1:0] amount, cfg_reg_t target,
                                    logic [3:0] value, logic pinned, alloc_result_t want);
        row_t r;
        r           = '0;
        r.kind      = kind;
        r.op        = op;
        r.part      = part;
        r.amount    = amount;
        r.target    = target;
        r.reg_value = value;
        r.pinned    = pinned;
        r.want      = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_item(func_t op, logic [2:0] part, logic [SIZE_W-1:0] amount);
        add_row(ROW_ITEM, op, part, amount, CFG_FIT_POLICY, 4'd0, 1'b0, '0);
    endfunction

    function automatic void add_known(func_t op, logic [2:0] part, logic [SIZE_W-1:0] amount,
                                      logic granted, logic [2:0] idx, logic [SIZE_W-1:0] left);
        add_row(ROW_ITEM, op, part, amount, CFG_FIT_POLICY, 4'd0, 1'b1, {granted, idx, left});
    endfunction

    function automatic void add_write(cfg_reg_t target, logic [3:0] value);
        add_row(ROW_REG, FUNC_NONE, 3'd0, '0, target, value, 1'b0, '0);
    endfunction

    function automatic void build_directed_rows();
        // fresh table: every partition empty, first fit over all eight
        add_known(FUNC_READ,  3'd0, 16'h0000, 1'b1, 3'd0, 16'h0000);
        add_known(FUNC_READ,  3'd7, 16'h0000, 1'b1, 3'd7, 16'h0000);
        add_known(FUNC_ALLOC, 3'd5, 16'h0000, 1'b1, 3'd0, 16'h0000);  // zero request, empty part
        add_known(FUNC_ALLOC, 3'd0, 16'h0001, 1'b0, 3'd0, 16'h0000);  // nothing fits
        add_known(FUNC_NONE,  3'd7, 16'hffff, 1'b0, 3'd0, 16'h0000);  // unused function code
        add_known(FUNC_LOAD,  3'd0, 16'hffff, 1'b1, 3'd0, 16'hffff);
        add_known(FUNC_LOAD,  3'd2, 16'h0300, 1'b1, 3'd2, 16'h0300);
        add_known(FUNC_LOAD,  3'd5, 16'h0100, 1'b1, 3'd5, 16'h0100);
        add_known(FUNC_LOAD,  3'd7, 16'haaaa, 1'b1, 3'd7, 16'haaaa);
        add_known(FUNC_LOAD,  3'd3, 16'h5555, 1'b1, 3'd3, 16'h5555);
        add_known(FUNC_ALLOC, 3'd0, 16'hffff, 1'b1, 3'd0, 16'h0000);  // largest request drains it
        add_item (FUNC_ALLOC, 3'd0, 16'h0100);
        // best fit: exact fit wins, then a tie goes to the lower index
        add_write(CFG_FIT_POLICY, 4'(POL_BEST));
        add_item (FUNC_ALLOC, 3'd0, 16'h0100);
        add_known(FUNC_LOAD,  3'd4, 16'h0200, 1'b1, 3'd4, 16'h0200);
        add_item (FUNC_ALLOC, 3'd0, 16'h0080);
        // worst fit with two equal largest partitions
        add_write(CFG_FIT_POLICY, 4'(POL_WORST));
        add_known(FUNC_LOAD,  3'd6, 16'haaaa, 1'b1, 3'd6, 16'haaaa);
        add_item (FUNC_ALLOC, 3'd0, 16'h0001);
        // unused policy code falls back to first fit
        add_write(CFG_FIT_POLICY, 4'(POL_RSVD));
        add_item (FUNC_ALLOC, 3'd0, 16'h0300);
        // empty scan window refuses even a zero request
        add_write(CFG_BLOCKS_IN_USE, 4'd0);
        add_known(FUNC_ALLOC, 3'd0, 16'h0000, 1'b0, 3'd0, 16'h0000);
        // oversized scan count saturates, so the top partition is reachable
        add_write(CFG_BLOCKS_IN_USE, 4'd15);
        add_item (FUNC_ALLOC, 3'd0, 16'haaaa);
        // single partition window
        add_write(CFG_BLOCKS_IN_USE, 4'd1);
        add_known(FUNC_ALLOC, 3'd0, 16'h0000, 1'b1, 3'd0, 16'h0000);
        add_item (FUNC_ALLOC, 3'd0, 16'h0001);
        add_write(CFG_SPARE2, 4'hf);
        add_write(CFG_SPARE3, 4'h0);
        add_write(CFG_FIT_POLICY, 4'(POL_FIRST));
        add_write(CFG_BLOCKS_IN_USE, 4'd8);
    endfunction

    // ---------------------------------------------------------------- drivers

    // hands one item to the block, with an optional sender gap in front
    task automatic offer_item(func_t op, logic [2:0] part, logic [SIZE_W-1:0] amount,
                              logic pinned, alloc_result_t want);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= {{(BUS_W - SIZE_W - 3){1'b0}}, amount, part};
        fixed_on   <= pinned;
        fixed_want <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // register writes only land on an idle block
    task automatic write_register(cfg_reg_t target, logic [3:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= target;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        logic [31:0] rnd;
        int          sel;
        int          bucket;
        func_t       op;
        logic [2:0]  part;
        rnd    = $urandom;
        part   = rnd[2:0];
        sel    = $urandom_range(0, 99);
        bucket = $urandom_range(0, 5);
        // allocations dominate, loads keep the table stocked
        if (sel < 28)      op = FUNC_LOAD;
        else if (sel < 78) op = FUNC_ALLOC;
        else if (sel < 94) op = FUNC_READ;
        else               op = FUNC_NONE;
        if (op == FUNC_LOAD) begin
            case (bucket)
                0:       rnd = 32'h0000_ffff;
                1:       rnd = $urandom;
                2:       rnd = $urandom_range(1, 8) << 8;  // coarse sizes make ties likely
                default: rnd = $urandom_range(0, 4095);
            endcase
        end else begin
            case (bucket)
                0:       rnd = 32'h0;
                1:       rnd = $urandom;
                2:       rnd = $urandom_range(1, 8) << 7;
                default: rnd = $urandom_range(1, 700);
            endcase
        end
        offer_item(op, part, rnd[SIZE_W-1:0], 1'b0, '0);
    endtask

    // receiver: ready most of the time, with stall bursts of random length
    initial begin : result_sink
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct))
                @(posedge aclk);
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string field, logic [SIZE_W-1:0] want,
                                        logic [SIZE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        alloc_result_t got;
        alloc_result_t want;
        alloc_result_t calc;
        if (aresetn) begin
            // results first: a result leaving never belongs to an item entering this edge
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[2:0], m_tdata[SIZE_W+2:3]};
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, granted %0b index %0d left %0h",
                             $time, got.granted, got.part, got.remain);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("granted", want.granted, got.granted);
                    check_field("chosen_index", want.part, got.part);
                    check_field("size_left", want.remain, got.remain);
                end
            end
            if (s_tvalid && s_tready) begin
                // the bench table always advances, a known answer replaces the prediction
                calc = predict_partition_op(func_t'(s_tuser), s_tdata[2:0], s_tdata[SIZE_W+2:3]);
                awaited_results.push_back(fixed_on ? fixed_want : calc);
            end
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_reg_t'(cfg_index), cfg_data);
            end
            // watchdog on any handshake at all
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("%0t ns: no handshake for %0d cycles", $time, STUCK_LIMIT);
                    $display("partition_fit_allocator_core regression: fail");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        row_t        row;
        policy_t     pol;
        logic [31:0] rnd;
        logic [3:0]  scan;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        fixed_on       = 1'b0;
        fixed_want     = '0;
        mismatches     = 0;
        stuck_cycles   = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        clear_partition_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, light idling on both sides
        src_gap_pct    = 20;
        sink_stall_pct = 8;
        build_directed_rows();
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_REG) write_register(row.target, row.reg_value);
            else offer_item(row.op, row.part, row.amount, row.pinned, row.want);
        end

        // random part: one register setting per phase, extremes first
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin pol = POL_FIRST; scan = 4'd8;  end
                1: begin pol = POL_BEST;  scan = 4'd8;  end
                2: begin pol = POL_WORST; scan = 4'd8;  end
                3: begin pol = POL_RSVD;  scan = 4'd3;  end
                4: begin pol = POL_BEST;  scan = 4'd1;  end
                5: begin pol = POL_WORST; scan = 4'd15; end
                6: begin pol = POL_FIRST; scan = 4'd0;  end
                default: begin
                    rnd  = $urandom_range(0, 3);
                    pol  = policy_t'(rnd[1:0]);
                    rnd  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                       : $urandom_range(1, 8);
                    scan = rnd[3:0];
                end
            endcase
            write_register(CFG_FIT_POLICY, {2'b00, pol});
            write_register(CFG_BLOCKS_IN_USE, scan);
            // some phases run flat out, the last one always does
            if (ph == RANDOM_PHASES - 1 || ph % 4 == 0) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct    = $urandom_range(5, 40);
                sink_stall_pct = $urandom_range(2, 15);
            end
            repeat (PHASE_ITEMS) begin
                // now and then restock every partition before allocating further
                if ($urandom_range(0, 39) == 0) begin
                    for (int p = 0; p < PARTS; p++) begin
                        rnd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095);
                        offer_item(FUNC_LOAD, p[2:0], rnd[SIZE_W-1:0], 1'b0, '0);
                    end
                end
                random_item();
            end
        end

        wait_for_results();
        // catch any stray result that trails the last one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("partition_fit_allocator_core regression: pass");
        end else begin
            $display("partition_fit_allocator_core regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/pfa_pkg.sv
rtl/core/pfa_cell.sv
rtl/core/partition_fit_allocator_core.sv
bench/partition_fit_allocator_core_test.sv
